[hw/rtl/boundary_tag_heap_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Boundary tag heap allocator assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BTHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// next-cycle implication
`define BTHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

[hw/rtl/btha_pkg.sv]
// ----------------------------------------------------------------------------
// btha_pkg
// Arena geometry, request and status codes, and tag helpers.
// ----------------------------------------------------------------------------
package btha_pkg;

    localparam int ARENA_BYTES   = 65536;
    localparam int ARENA_WORDS   = ARENA_BYTES / 8;
    localparam int AW            = $clog2(ARENA_WORDS);
    localparam int MIN_CHUNK     = 32;
    localparam int FIRST_PAYLOAD = 32;
    localparam int WALK_LIMIT    = ARENA_BYTES / MIN_CHUNK + 1;
    localparam int CW            = $clog2(WALK_LIMIT + 1);

    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_FREE    = 3'd1;
    localparam logic [2:0] REQ_REALLOC = 3'd2;
    localparam logic [2:0] REQ_READ    = 3'd3;
    localparam logic [2:0] REQ_WRITE   = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NULL  = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    localparam logic [63:0] SIZE_MASK = ~64'h7;

    function automatic logic [AW-1:0] widx(input logic [63:0] a);
        return a[AW+2:3];
    endfunction

    function automatic logic [63:0] round_block(input logic [15:0] s);
        logic [16:0] need;
        logic [17:0] up;
        need = {1'b0, s} + 17'd16;
        up   = {1'b0, need} + 18'd15;
        if (need < 17'(MIN_CHUNK)) begin
            return 64'(MIN_CHUNK);
        end
        return {46'd0, up[17:4], 4'd0};
    endfunction

    function automatic logic [63:0] init_word(input logic [AW-1:0] i);
        if (i == AW'(1) || i == AW'(2)) begin
            return 64'd17;
        end
        if (i == AW'(3) || i == AW'(ARENA_WORDS - 2)) begin
            return 64'(ARENA_BYTES - 32);
        end
        if (i == AW'(ARENA_WORDS - 1)) begin
            return 64'd1;
        end
        return 64'd0;
    endfunction

endpackage

[hw/rtl/boundary_tag_heap_allocator.sv]
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// First-fit explicit free list allocator with boundary tags over its own arena.
// ----------------------------------------------------------------------------
// Heap state other than the free list head (a register) lives in one
// single-port-write arena RAM with a registered read; a sequencer performs
// the tag and link accesses one at a time. After reset the arena is built by
// a sweep over all ARENA_WORDS (8192) words with busy high. A request is
// taken when start is high and busy low; its one result appears on o_valid
// for a single cycle and cannot be held off. Realloc by move copies the
// payload word by word before it frees the old block.
module boundary_tag_heap_allocator
    import btha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_block_addr,
    input  logic [15:0] i_req_size,
    input  logic [63:0] i_write_data,
    output logic        o_valid,
    output logic [15:0] o_result_addr,
    output logic [1:0]  o_status,
    output logic [63:0] o_read_data
);
`include "boundary_tag_heap_allocator_defines.svh"

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_DISP, S_RDW, S_FIN, S_FRCHK,
        S_REL0, S_REL1, S_MF0, S_MF1, S_MF2, S_MF3, S_MF4, S_MF5, S_MF6, S_MF7,
        S_LR0, S_LR1, S_LR2, S_LR3, S_LI0, S_LI1, S_LI2, S_TG0, S_TG1,
        S_AL0, S_FF0, S_FF1, S_FF2, S_PL0, S_PL1, S_PL2, S_PL3, S_PLD,
        S_RACHK, S_RAZ, S_RA1, S_RAS1, S_RAS2, S_RARET, S_RA2,
        S_RAG1, S_RAG2, S_RAG3, S_RAG4, S_RAM1, S_CP0, S_CP1
    } t_state;

    logic [63:0] r_mem [ARENA_WORDS];
    logic [63:0] r_q;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [63:0]   mem_wd;

    t_state r_state, n_state;
    t_state r_ret_lr, n_ret_lr, r_ret_li, n_ret_li, r_ret_tg, n_ret_tg;
    t_state r_ret_rel, n_ret_rel, r_ret_al, n_ret_al;
    logic          r_valid, n_valid;
    logic [AW-1:0] r_icnt, n_icnt;
    logic [63:0]   r_head, n_head;

    logic [2:0]  r_type, n_type;
    logic [15:0] r_addr, n_addr, r_reqsz, n_reqsz, r_res, n_res;
    logic [63:0] r_wdata, n_wdata, r_data, n_data;
    logic [1:0]  r_st, n_st;
    logic [63:0] r_rbp, n_rbp, r_rsize, n_rsize, r_pw, n_pw, r_nb, n_nb, r_pb, n_pb;
    logic        r_na, n_na;
    logic [63:0] r_lbp, n_lbp, r_lp, n_lp, r_ln, n_ln, r_ibp, n_ibp;
    logic [63:0] r_tbp, n_tbp, r_tsize, n_tsize, r_tval, n_tval;
    logic [63:0] r_node, n_node, r_asize, n_asize, r_pcsize, n_pcsize;
    logic [63:0] r_csize, n_csize, r_comb, n_comb, r_fresh, n_fresh;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW:0]   r_i, n_i, r_n, n_n;

    logic [63:0] w_p, w_qsz, w_cm16, w_words;
    logic        w_ok;

    assign w_p     = {48'd0, r_addr};
    assign w_qsz   = r_q & SIZE_MASK;
    assign w_ok    = r_addr[3:0] == 4'd0 && r_addr >= 16'(FIRST_PAYLOAD) &&
                     32'(r_addr) < 32'(ARENA_BYTES) && r_q[0];
    assign w_cm16  = r_csize - 64'd16;
    assign w_words = w_cm16 >> 3;

    assign busy          = r_state != S_IDLE;
    assign o_valid       = r_valid;
    assign o_result_addr = r_res;
    assign o_status      = r_st;
    assign o_read_data   = r_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_q <= r_mem[mem_ra];
    end

    always_comb begin
        n_state = r_state;  n_ret_lr = r_ret_lr; n_ret_li = r_ret_li;
        n_ret_tg = r_ret_tg; n_ret_rel = r_ret_rel; n_ret_al = r_ret_al;
        n_valid = 1'b0;     n_icnt = r_icnt;     n_head = r_head;
        n_type = r_type;    n_addr = r_addr;     n_reqsz = r_reqsz;
        n_res = r_res;      n_wdata = r_wdata;   n_data = r_data;  n_st = r_st;
        n_rbp = r_rbp;      n_rsize = r_rsize;   n_pw = r_pw;      n_nb = r_nb;
        n_pb = r_pb;        n_na = r_na;         n_lbp = r_lbp;    n_lp = r_lp;
        n_ln = r_ln;        n_ibp = r_ibp;       n_tbp = r_tbp;    n_tsize = r_tsize;
        n_tval = r_tval;    n_node = r_node;     n_asize = r_asize;
        n_pcsize = r_pcsize; n_csize = r_csize;  n_comb = r_comb;  n_fresh = r_fresh;
        n_cnt = r_cnt;      n_i = r_i;           n_n = r_n;
        mem_we = 1'b0;      mem_wa = '0;         mem_wd = '0;      mem_ra = '0;

        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_icnt;
                mem_wd = init_word(r_icnt);
                n_icnt = r_icnt + AW'(1);
                if (r_icnt == AW'(ARENA_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_type  = i_req_type;
                    n_addr  = i_block_addr;
                    n_reqsz = i_req_size;
                    n_wdata = i_write_data;
                    n_res   = '0;
                    n_st    = ST_DONE;
                    n_data  = '0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                mem_ra = widx(w_p - 64'd8);
                case (r_type)
                    REQ_ALLOC: begin
                        n_ret_al = S_FIN;
                        n_state  = S_AL0;
                    end
                    REQ_FREE: begin
                        n_state = (r_addr == 16'd0) ? S_FIN : S_FRCHK;
                    end
                    REQ_REALLOC: begin
                        n_ret_al = S_FIN;
                        n_state  = (r_addr == 16'd0) ? S_AL0 : S_RACHK;
                    end
                    REQ_READ: begin
                        mem_ra  = widx(w_p);
                        n_state = S_RDW;
                    end
                    REQ_WRITE: begin
                        mem_we  = 1'b1;
                        mem_wa  = widx(w_p);
                        mem_wd  = r_wdata;
                        n_state = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_RDW: begin
                n_data  = r_q;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_FRCHK: begin
                if (w_ok) begin
                    n_rbp = w_p; n_ret_rel = S_FIN; n_state = S_REL0;
                end else begin
                    n_state = S_FIN;
                end
            end

            // release: retag free, then coalesce and push on the list
            S_REL0: begin
                mem_ra  = widx(r_rbp - 64'd8);
                n_state = S_REL1;
            end
            S_REL1: begin
                n_rsize = w_qsz;
                n_tbp = r_rbp; n_tsize = w_qsz; n_tval = w_qsz;
                n_ret_tg = S_MF0; n_state = S_TG0;
            end
            S_MF0: begin
                mem_ra  = widx(r_rbp - 64'd16);
                n_state = S_MF1;
            end
            S_MF1: begin
                n_pw    = r_q;
                n_nb    = r_rbp + r_rsize;
                mem_ra  = widx(r_rbp + r_rsize - 64'd8);
                n_state = S_MF2;
            end
            S_MF2: begin
                n_na = r_q[0];
                n_pb = r_rbp - (r_pw & SIZE_MASK);
                if (!r_pw[0]) begin
                    n_lbp = r_rbp - (r_pw & SIZE_MASK);
                    n_ret_lr = S_MF3; n_state = S_LR0;
                end else begin
                    n_state = S_MF3;
                end
            end
            S_MF3: begin
                if (!r_na) begin
                    n_lbp = r_nb; n_ret_lr = S_MF4; n_state = S_LR0;
                end else begin
                    n_state = S_MF4;
                end
            end
            S_MF4: begin
                if (r_pw[0] && r_na) begin
                    n_ibp = r_rbp; n_ret_li = r_ret_rel; n_state = S_LI0;
                end else begin
                    mem_ra  = widx(r_pb - 64'd8);
                    n_state = S_MF5;
                end
            end
            S_MF5: begin
                if (!r_pw[0]) begin
                    n_rsize = r_rsize + w_qsz;
                end
                mem_ra  = widx(r_nb - 64'd8);
                n_state = S_MF6;
            end
            S_MF6: begin
                n_tsize = r_na ? r_rsize : r_rsize + w_qsz;
                n_tbp   = r_pw[0] ? r_rbp : r_pb;
                n_tval  = n_tsize;
                n_rsize = n_tsize;
                n_rbp   = n_tbp;
                n_ret_tg = S_MF7; n_state = S_TG0;
            end
            S_MF7: begin
                n_ibp = r_rbp; n_ret_li = r_ret_rel; n_state = S_LI0;
            end

            // list unlink
            S_LR0: begin
                mem_ra  = widx(r_lbp);
                n_state = S_LR1;
            end
            S_LR1: begin
                n_lp    = r_q;
                mem_ra  = widx(r_lbp + 64'd8);
                n_state = S_LR2;
            end
            S_LR2: begin
                n_ln = r_q;
                if (r_lp != 64'd0) begin
                    mem_we = 1'b1;
                    mem_wa = widx(r_lp + 64'd8);
                    mem_wd = r_q;
                end else begin
                    n_head = r_q;
                end
                n_state = S_LR3;
            end
            S_LR3: begin
                if (r_ln != 64'd0) begin
                    mem_we = 1'b1;
                    mem_wa = widx(r_ln);
                    mem_wd = r_lp;
                end
                n_state = r_ret_lr;
            end

            // list push at head
            S_LI0: begin
                mem_we = 1'b1; mem_wa = widx(r_ibp); mem_wd = '0;
                n_state = S_LI1;
            end
            S_LI1: begin
                mem_we = 1'b1; mem_wa = widx(r_ibp + 64'd8); mem_wd = r_head;
                n_state = S_LI2;
            end
            S_LI2: begin
                if (r_head != 64'd0) begin
                    mem_we = 1'b1; mem_wa = widx(r_head); mem_wd = r_ibp;
                end
                n_head  = r_ibp;
                n_state = r_ret_li;
            end

            // header and footer
            S_TG0: begin
                mem_we = 1'b1; mem_wa = widx(r_tbp - 64'd8); mem_wd = r_tval;
                n_state = S_TG1;
            end
            S_TG1: begin
                mem_we = 1'b1; mem_wa = widx(r_tbp + r_tsize - 64'd16); mem_wd = r_tval;
                n_state = r_ret_tg;
            end

            // first-fit alloc
            S_AL0: begin
                if (r_reqsz == 16'd0) begin
                    n_st = ST_NULL; n_res = '0; n_state = r_ret_al;
                end else begin
                    n_asize = round_block(r_reqsz);
                    n_node  = r_head;
                    n_cnt   = '0;
                    n_state = S_FF0;
                end
            end
            S_FF0: begin
                if (r_cnt >= CW'(WALK_LIMIT) || r_node == 64'd0) begin
                    n_st = ST_NOFIT; n_res = '0; n_fresh = '0; n_state = r_ret_al;
                end else begin
                    mem_ra  = widx(r_node - 64'd8);
                    n_state = S_FF1;
                end
            end
            S_FF1: begin
                if (w_qsz >= r_asize) begin
                    n_pcsize = w_qsz;
                    n_state  = S_PL0;
                end else begin
                    mem_ra  = widx(r_node + 64'd8);
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_FF2;
                end
            end
            S_FF2: begin
                n_node  = r_q;
                n_state = S_FF0;
            end
            S_PL0: begin
                n_lbp = r_node; n_ret_lr = S_PL1; n_state = S_LR0;
            end
            S_PL1: begin
                n_tbp = r_node;
                n_ret_tg = S_PLD; n_state = S_TG0;
                if (r_pcsize >= r_asize && r_pcsize - r_asize >= 64'(MIN_CHUNK)) begin
                    n_tsize = r_asize; n_tval = r_asize | 64'd1; n_ret_tg = S_PL2;
                end else begin
                    n_tsize = r_pcsize; n_tval = r_pcsize | 64'd1;
                end
            end
            S_PL2: begin
                n_tbp = r_node + r_asize;
                n_tsize = r_pcsize - r_asize; n_tval = r_pcsize - r_asize;
                n_ret_tg = S_PL3; n_state = S_TG0;
            end
            S_PL3: begin
                n_ibp = r_node + r_asize; n_ret_li = S_PLD; n_state = S_LI0;
            end
            S_PLD: begin
                n_res = r_node[15:0]; n_fresh = r_node; n_st = ST_DONE;
                n_state = r_ret_al;
            end

            // realloc
            S_RACHK: begin
                if (!w_ok) begin
                    n_st = ST_NOFIT; n_state = S_FIN;
                end else if (r_reqsz == 16'd0) begin
                    n_rbp = w_p; n_ret_rel = S_RAZ; n_state = S_REL0;
                end else begin
                    n_asize = round_block(r_reqsz);
                    n_csize = w_qsz;
                    n_state = S_RA1;
                end
            end
            S_RAZ: begin
                n_st = ST_NULL; n_state = S_FIN;
            end
            S_RA1: begin
                if (r_asize <= r_csize) begin
                    if (r_csize - r_asize >= 64'(MIN_CHUNK)) begin
                        n_tbp = w_p; n_tsize = r_asize; n_tval = r_asize | 64'd1;
                        n_ret_tg = S_RAS1; n_state = S_TG0;
                    end else begin
                        n_state = S_RARET;
                    end
                end else begin
                    n_nb    = w_p + r_csize;
                    mem_ra  = widx(w_p + r_csize - 64'd8);
                    n_state = S_RA2;
                end
            end
            S_RAS1: begin
                n_tbp = w_p + r_asize;
                n_tsize = r_csize - r_asize; n_tval = (r_csize - r_asize) | 64'd1;
                n_ret_tg = S_RAS2; n_state = S_TG0;
            end
            S_RAS2: begin
                n_rbp = w_p + r_asize; n_ret_rel = S_RARET; n_state = S_REL0;
            end
            S_RARET: begin
                n_res = r_addr; n_st = ST_DONE; n_state = S_FIN;
            end
            S_RA2: begin
                if (!r_q[0] && r_csize + w_qsz >= r_asize) begin
                    n_comb = r_csize + w_qsz;
                    n_lbp = r_nb; n_ret_lr = S_RAG1; n_state = S_LR0;
                end else begin
                    n_ret_al = S_RAM1; n_state = S_AL0;
                end
            end
            S_RAG1: begin
                n_tbp = w_p; n_tsize = r_comb; n_tval = r_comb | 64'd1;
                n_ret_tg = S_RAG2; n_state = S_TG0;
            end
            S_RAG2: begin
                if (r_comb - r_asize >= 64'(MIN_CHUNK)) begin
                    n_tbp = w_p; n_tsize = r_asize; n_tval = r_asize | 64'd1;
                    n_ret_tg = S_RAG3; n_state = S_TG0;
                end else begin
                    n_state = S_RARET;
                end
            end
            S_RAG3: begin
                n_tbp = w_p + r_asize;
                n_tsize = r_comb - r_asize; n_tval = r_comb - r_asize;
                n_ret_tg = S_RAG4; n_state = S_TG0;
            end
            S_RAG4: begin
                n_ibp = w_p + r_asize; n_ret_li = S_RARET; n_state = S_LI0;
            end
            S_RAM1: begin
                if (r_fresh == 64'd0) begin
                    n_st = ST_NOFIT; n_res = '0; n_state = S_FIN;
                end else begin
                    n_i = '0;
                    if (r_csize < 64'd16) begin
                        n_n = '0;
                    end else if (w_words > 64'(ARENA_WORDS)) begin
                        n_n = (AW+1)'(ARENA_WORDS);
                    end else begin
                        n_n = w_words[AW:0];
                    end
                    n_state = S_CP0;
                end
            end
            S_CP0: begin
                if (r_i >= r_n) begin
                    n_rbp = w_p; n_ret_rel = S_FIN; n_state = S_REL0;
                end else begin
                    mem_ra  = widx(w_p) + r_i[AW-1:0];
                    n_state = S_CP1;
                end
            end
            S_CP1: begin
                mem_we  = 1'b1;
                mem_wa  = widx(r_fresh) + r_i[AW-1:0];
                mem_wd  = r_q;
                n_i     = r_i + (AW+1)'(1);
                n_state = S_CP0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_icnt  <= '0;
            r_head  <= 64'(FIRST_PAYLOAD);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_icnt  <= n_icnt;
            r_head  <= n_head;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret_lr <= n_ret_lr; r_ret_li <= n_ret_li; r_ret_tg <= n_ret_tg;
        r_ret_rel <= n_ret_rel; r_ret_al <= n_ret_al;
        r_type <= n_type;   r_addr <= n_addr;   r_reqsz <= n_reqsz;
        r_res <= n_res;     r_wdata <= n_wdata; r_data <= n_data;  r_st <= n_st;
        r_rbp <= n_rbp;     r_rsize <= n_rsize; r_pw <= n_pw;      r_nb <= n_nb;
        r_pb <= n_pb;       r_na <= n_na;       r_lbp <= n_lbp;    r_lp <= n_lp;
        r_ln <= n_ln;       r_ibp <= n_ibp;     r_tbp <= n_tbp;    r_tsize <= n_tsize;
        r_tval <= n_tval;   r_node <= n_node;   r_asize <= n_asize;
        r_pcsize <= n_pcsize; r_csize <= n_csize; r_comb <= n_comb; r_fresh <= n_fresh;
        r_cnt <= n_cnt;     r_i <= n_i;         r_n <= n_n;
    end

    `BTHA_ASSERT_NXT(a_take_sets_busy, i_clk, i_rst_n, start && !busy, busy)
    `BTHA_ASSERT_IMP(a_beat_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `BTHA_ASSERT_IMP(a_nofit_null, i_clk, i_rst_n, o_valid && o_status == ST_NOFIT, o_result_addr == '0)
    `BTHA_ASSERT_NXT(a_one_beat, i_clk, i_rst_n, o_valid, !o_valid)

endmodule

[sim/tb_boundary_tag_heap_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_boundary_tag_heap_allocator
// Drives alloc, free, realloc, word read/write and undefined command codes
// into the heap allocator and compares every result beat against a behavioral
// heap kept in the testbench.
// ----------------------------------------------------------------------------
module tb_boundary_tag_heap_allocator;
    import btha_pkg::*;

    localparam longint MAX_CYCLES = 40000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_req_type;
    logic [15:0] i_block_addr;
    logic [15:0] i_req_size;
    logic [63:0] i_write_data;
    logic        o_valid;
    logic [15:0] o_result_addr;
    logic [1:0]  o_status;
    logic [63:0] o_read_data;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
        logic [63:0] data;
    } t_heap_result;

    // behavioral heap
    logic [63:0] heap_mem [ARENA_WORDS];
    logic [63:0] heap_free_head;

    function automatic logic [63:0] hr(logic [63:0] a);
        return heap_mem[a[AW+2:3]];
    endfunction

    function automatic void hw(logic [63:0] a, logic [63:0] v);
        heap_mem[a[AW+2:3]] = v;
    endfunction

    function automatic logic [63:0] blk_size(logic [63:0] bp);
        return hr(bp - 8) & SIZE_MASK;
    endfunction

    function automatic void set_tags(logic [63:0] bp, logic [63:0] sz, logic [63:0] al);
        hw(bp - 8, sz | al);
        hw(bp + sz - 16, sz | al);
    endfunction

    function automatic void link_in(logic [63:0] bp);
        hw(bp, 0);
        hw(bp + 8, heap_free_head);
        if (heap_free_head != 0) hw(heap_free_head, bp);
        heap_free_head = bp;
    endfunction

    function automatic void unlink(logic [63:0] bp);
        logic [63:0] p, n;
        p = hr(bp);
        n = hr(bp + 8);
        if (p != 0) hw(p + 8, n); else heap_free_head = n;
        if (n != 0) hw(n, p);
    endfunction

    function automatic void coalesce(logic [63:0] bp);
        logic [63:0] pw, sz, nb, pb, nw;
        logic pa, na;
        pw = hr(bp - 16);
        sz = blk_size(bp);
        nb = bp + sz;
        pa = pw[0];
        nw = hr(nb - 8);
        na = nw[0];
        pb = bp - (pw & SIZE_MASK);
        if (pa && !na) begin
            unlink(nb);
            sz += blk_size(nb);
            set_tags(bp, sz, 0);
        end else if (!pa && na) begin
            unlink(pb);
            sz += blk_size(pb);
            bp = pb;
            set_tags(bp, sz, 0);
        end else if (!pa && !na) begin
            unlink(pb);
            unlink(nb);
            sz += blk_size(pb) + blk_size(nb);
            bp = pb;
            set_tags(bp, sz, 0);
        end
        link_in(bp);
    endfunction

    function automatic void heap_release(logic [63:0] bp);
        set_tags(bp, blk_size(bp), 0);
        coalesce(bp);
    endfunction

    function automatic bit valid_ptr(logic [63:0] bp);
        return bp[3:0] == 0 && bp >= FIRST_PAYLOAD && bp < ARENA_BYTES && hr(bp - 8) & 64'h1;
    endfunction

    function automatic logic [63:0] block_need(logic [63:0] s);
        logic [63:0] need;
        need = s + 16;
        if (need < MIN_CHUNK) return 64'(MIN_CHUNK);
        return (need + 15) & ~64'd15;
    endfunction

    function automatic logic [63:0] find_fit(logic [63:0] asz);
        logic [63:0] node;
        node = heap_free_head;
        for (int i = 0; i < WALK_LIMIT && node != 0; i++) begin
            if (blk_size(node) >= asz) return node;
            node = hr(node + 8);
        end
        return 0;
    endfunction

    function automatic void carve(logic [63:0] bp, logic [63:0] asz);
        logic [63:0] cs;
        cs = blk_size(bp);
        unlink(bp);
        if (cs >= asz && cs - asz >= MIN_CHUNK) begin
            set_tags(bp, asz, 1);
            set_tags(bp + asz, cs - asz, 0);
            link_in(bp + asz);
        end else begin
            set_tags(bp, cs, 1);
        end
    endfunction

    function automatic logic [63:0] heap_alloc(logic [63:0] s, output logic [1:0] st);
        logic [63:0] asz, bp;
        if (s == 0) begin st = ST_NULL; return 0; end
        asz = block_need(s);
        bp = find_fit(asz);
        if (bp == 0) begin st = ST_NOFIT; return 0; end
        carve(bp, asz);
        st = ST_DONE;
        return bp;
    endfunction

    function automatic logic [63:0] heap_realloc(logic [63:0] p, logic [63:0] s,
                                                 output logic [1:0] st);
        logic [63:0] asz, cs, nb, fr, n, comb, nw;
        if (p == 0) return heap_alloc(s, st);
        if (!valid_ptr(p)) begin st = ST_NOFIT; return 0; end
        if (s == 0) begin heap_release(p); st = ST_NULL; return 0; end
        asz = block_need(s);
        cs = blk_size(p);
        st = ST_DONE;
        if (asz <= cs) begin
            if (cs - asz >= MIN_CHUNK) begin
                set_tags(p, asz, 1);
                set_tags(p + asz, cs - asz, 1);
                heap_release(p + asz);
            end
            return p;
        end
        nb = p + cs;
        nw = hr(nb - 8);
        if (!nw[0] && cs + blk_size(nb) >= asz) begin
            comb = cs + blk_size(nb);
            unlink(nb);
            set_tags(p, comb, 1);
            if (comb - asz >= MIN_CHUNK) begin
                set_tags(p, asz, 1);
                set_tags(p + asz, comb - asz, 0);
                link_in(p + asz);
            end
            return p;
        end
        fr = heap_alloc(s, st);
        if (fr == 0) begin st = ST_NOFIT; return 0; end
        n = cs >= 16 ? (cs - 16) / 8 : 0;
        if (n > ARENA_WORDS) n = ARENA_WORDS;
        for (longint i = 0; i < n; i++) hw(fr + 8 * i, hr(p + 8 * i));
        heap_release(p);
        st = ST_DONE;
        return fr;
    endfunction

    function automatic void heap_reset();
        for (int i = 0; i < ARENA_WORDS; i++) heap_mem[i] = 0;
        hw(8, 17);
        hw(16, 17);
        set_tags(FIRST_PAYLOAD, ARENA_BYTES - 32, 0);
        hw(ARENA_BYTES - 8, 1);
        heap_free_head = 0;
        link_in(FIRST_PAYLOAD);
    endfunction

    function automatic t_heap_result heap_step(logic [2:0] t, logic [15:0] a,
                                               logic [15:0] s, logic [63:0] d);
        t_heap_result r;
        logic [63:0] res;
        logic [1:0] st;
        res = 0;
        st = ST_DONE;
        r.data = 0;
        case (t)
            REQ_ALLOC:   res = heap_alloc(64'(s), st);
            REQ_FREE:    if (a != 0 && valid_ptr(64'(a))) heap_release(64'(a));
            REQ_REALLOC: res = heap_realloc(64'(a), 64'(s), st);
            REQ_READ:    r.data = hr(64'(a));
            REQ_WRITE:   hw(64'(a), d);
            default: ;
        endcase
        r.addr = res[15:0];
        r.status = st;
        return r;
    endfunction

    class t_heap_scoreboard;
        t_heap_result pending[$];
        int mismatches;

        function void note_beat(logic [2:0] t, logic [15:0] a, logic [15:0] s,
                                logic [63:0] d);
            pending.push_back(heap_step(t, a, s, d));
        endfunction

        function void check_beat(t_heap_result got);
            t_heap_result exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp addr %h st %0d data %h, got addr %h st %0d data %h",
                             exp.addr, exp.status, exp.data, got.addr, got.status, got.data);
            end
        endfunction
    endclass

    t_heap_scoreboard sb;
    logic [15:0] live_ptrs[$];
    bit quiet;
    longint cycles = 0;

    boundary_tag_heap_allocator uut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            sb.check_beat('{o_result_addr, o_status, o_read_data});
            if (o_result_addr != 0 && live_ptrs.size() < 64) live_ptrs.push_back(o_result_addr);
        end
        if (i_rst_n && start && !busy)
            sb.note_beat(i_req_type, i_block_addr, i_req_size, i_write_data);
        if (cycles > MAX_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // start stays high between back-to-back commands; a gap drops it first
    task automatic send_cmd(logic [2:0] t, logic [15:0] a, logic [15:0] s, logic [63:0] d);
        int gap;
        if (!quiet && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1;
        i_req_type <= t;
        i_block_addr <= a;
        i_req_size <= s;
        i_write_data <= d;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_ptr();
        int k;
        if (live_ptrs.size() == 0) return 16'($urandom_range(2, 4000) * 16);
        k = $urandom_range(live_ptrs.size() - 1);
        pick_ptr = live_ptrs[k];
        live_ptrs.delete(k);
    endfunction

    task automatic random_cmd();
        int r;
        logic [15:0] sz;
        logic [15:0] p;
        r = $urandom_range(99);
        sz = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        if (r < 30) send_cmd(REQ_ALLOC, 16'($urandom), sz, 0);
        else if (r < 52) send_cmd(REQ_FREE, ($urandom_range(9) == 0) ? 16'($urandom) : pick_ptr(),
                                  sz, 0);
        else if (r < 70) begin
            p = ($urandom_range(9) == 0) ? 16'($urandom) : pick_ptr();
            if ($urandom_range(9) == 0) p = 0;
            send_cmd(REQ_REALLOC, p, sz, 0);
        end else if (r < 84) send_cmd(REQ_READ, ($urandom_range(1) == 0) ? 16'($urandom) :
                                      16'($urandom_range(0, 2047)), 0, {$urandom, $urandom});
        else if (r < 96) begin
            p = (live_ptrs.size() > 0) ?
                live_ptrs[$urandom_range(live_ptrs.size() - 1)] + 16'd16 : 16'($urandom);
            send_cmd(REQ_WRITE, p, 16'($urandom), {$urandom, $urandom});
        end else send_cmd(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                          {$urandom, $urandom});
    endtask

    initial begin
        int wait_cnt;
        sb = new();
        heap_reset();
        quiet = 0;
        start = 0;
        i_req_type = 0;
        i_block_addr = 0;
        i_req_size = 0;
        i_write_data = 0;
        i_rst_n = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;

        send_cmd(REQ_ALLOC, 0, 0, 0);
        send_cmd(REQ_ALLOC, 0, 1, 0);
        send_cmd(REQ_ALLOC, 0, 16, 0);
        send_cmd(REQ_ALLOC, 0, 17, 0);
        send_cmd(REQ_ALLOC, 0, 100, 0);
        send_cmd(REQ_ALLOC, 0, 16'hFFFF, 0);
        send_cmd(REQ_WRITE, 16'd48, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(REQ_READ, 16'd55, 0, 0);
        send_cmd(REQ_READ, 16'hFFFF, 0, 0);
        send_cmd(REQ_FREE, 0, 0, 0);
        send_cmd(REQ_FREE, 16'd40, 0, 0);
        send_cmd(REQ_FREE, 16'd16, 0, 0);
        send_cmd(REQ_FREE, 16'd64, 0, 0);
        send_cmd(REQ_FREE, 16'd64, 0, 0);
        send_cmd(REQ_REALLOC, 0, 40, 0);
        send_cmd(REQ_REALLOC, 16'd32, 8, 0);
        send_cmd(REQ_REALLOC, 16'd32, 200, 0);
        send_cmd(REQ_REALLOC, 16'd32, 16'hF000, 0);
        send_cmd(REQ_REALLOC, 16'd40, 10, 0);
        send_cmd(REQ_REALLOC, 16'd32, 0, 0);
        send_cmd(3'd7, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(3'd5, 0, 0, 0);
        live_ptrs.delete();

        for (int i = 0; i < 1100; i++) begin
            if (i == 950) quiet = 1;
            random_cmd();
        end
        start <= 0;

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 200000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (200) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
